/* hdl/pcxrle_pkg.sv */
// ----------------------------------------------------------------------------
// pcxrle_pkg
// shared types and constants of the pcx run-length scanline decoder
// ----------------------------------------------------------------------------
package pcxrle_pkg;

  localparam int MaxLineDef = 4096;   // default line buffer depth
  localparam int ByteW      = 8;
  localparam int ColW       = 12;
  localparam int RowW       = 16;
  localparam int CfgLenW    = 13;     // width of the length registers
  localparam int CfgDataW   = 16;     // widest register
  localparam int CfgIdxW    = 3;
  localparam int RunW       = 6;
  localparam int PlaneW     = 2;

  localparam logic [ByteW-1:0] RunFlag = 8'hc0;
  localparam logic [ByteW-1:0] RunMask = 8'h3f;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegTruecolor = 3'd0;
  localparam logic [CfgIdxW-1:0] RegBytesLine = 3'd1;
  localparam logic [CfgIdxW-1:0] RegWidth     = 3'd2;
  localparam logic [CfgIdxW-1:0] RegHeight    = 3'd3;
  localparam logic [CfgIdxW-1:0] RegCopy      = 3'd4;

  localparam logic [PlaneW-1:0] PlaneRed   = 2'd0;
  localparam logic [PlaneW-1:0] PlaneGreen = 2'd1;
  localparam logic [PlaneW-1:0] PlaneBlue  = 2'd2;

  typedef enum logic [1:0] {
    STAT_DATA     = 2'd0,
    STAT_ZERO_RUN = 2'd1,
    STAT_TRUNC    = 2'd2
  } status_e;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             end_of_data;
  } in_t;

  typedef struct packed {
    logic [ByteW-1:0] first_byte;
    logic [ByteW-1:0] green_value;
    logic [ByteW-1:0] red_value;
    logic [ColW-1:0]  column;
    logic [RowW-1:0]  row_index;
    logic             row_end;
    status_e          status;
    logic             last;
  } out_t;

endpackage

/* hdl/pcx_rle_scanline_decoder_core.sv */
// ----------------------------------------------------------------------------
// pcx_rle_scanline_decoder_core
// pcx run-length decoder with red and green line buffers for truecolor rows
// ----------------------------------------------------------------------------
// usage:
//   configuration is written on cfg_we_i / cfg_index_i / cfg_data_i while the
//   block is idle. coded bytes enter on in_valid_i / in_stall_o, one request
//   per byte. results leave on out_valid_o / out_stall_i; out_data_o.last
//   marks the final result caused by one request.
// sequence:
//   a literal byte is decoded, then checked for the end of its request; a
//   run header only arms the run; a run value is followed by the decoding
//   of its run bytes in turn and then the end-of-request check. the decode
//   step handles one decoded byte per cycle while the pending slot can take
//   it, and sets the rate. a result waits in a pending slot until it is
//   known whether more follow from the same request.
// reset:
//   decoder state and registers return to their defaults; line buffer
//   contents are not cleared and need no clearing pass.
// stall:
//   a stalled receiver holds the output register; one more result waits in
//   the pending slot, then decoding pauses and in_stall_o rises.
// ----------------------------------------------------------------------------
module pcx_rle_scanline_decoder_core #(
  parameter int MAX_LINE = pcxrle_pkg::MaxLineDef
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [pcxrle_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [pcxrle_pkg::CfgDataW-1:0]      cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  pcxrle_pkg::in_t                      in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output pcxrle_pkg::out_t                     out_data_o
);

  localparam int PosW = $clog2(MAX_LINE);
  localparam int CmpW = (PosW + 1 > pcxrle_pkg::CfgLenW) ? PosW + 1 : pcxrle_pkg::CfgLenW;
  localparam int RowW = pcxrle_pkg::RowW;
  localparam int ByteW = pcxrle_pkg::ByteW;
  localparam int LenW = pcxrle_pkg::CfgLenW;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  // configuration
  logic            truecolor_q;
  logic [LenW-1:0] bytes_line_q, width_q, copy_q;
  logic [RowW-1:0] height_q;

  // decoder state
  state_e                          state_q, state_d;
  logic [pcxrle_pkg::RunW-1:0]     run_rem_q, run_rem_d;
  logic [ByteW-1:0]                run_value_q, run_value_d;
  logic                            awaiting_q, awaiting_d;
  logic [pcxrle_pkg::PlaneW-1:0]   plane_q, plane_d;
  logic [PosW-1:0]                 pos_q, pos_d;
  logic [RowW-1:0]                 row_q, row_d;
  logic                            stopped_q, stopped_d;
  logic                            eod_q, eod_d;

  // line buffers
  logic [ByteW-1:0] red_mem [MAX_LINE];
  logic [ByteW-1:0] green_mem [MAX_LINE];
  logic [ByteW-1:0] rd_red_q, rd_green_q;
  logic             wr_red, wr_green, rd_en;

  // pending slot and output register
  logic              pend_valid_q, pend_final_q, pend_tc_q;
  pcxrle_pkg::out_t  pend_q;
  logic              out_valid_q;
  pcxrle_pkg::out_t  out_q, out_d;

  logic out_free, slot_ok, accept, active, run_go, done_go;
  logic is_header, zero_run;
  logic dec_fire, dec_emit, dec_stop;
  logic [ByteW-1:0] dec_val;
  logic [CmpW-1:0]  bpl_ext, bpl_eff, pos_ext, pos_inc, limit_ext, span;
  logic             last_plane, wrap, row_end;
  logic [RowW-1:0]  row_inc;
  logic             push, push_final, pend_move;
  pcxrle_pkg::out_t push_data;
  logic             err_hdr, err_done, done_check;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign slot_ok    = !pend_valid_q || out_free;
  assign in_stall_o = !((state_q == ST_IDLE) && slot_ok);
  assign accept     = in_valid_i && !in_stall_o;
  assign active     = accept && !(stopped_q || (row_q >= height_q));
  assign run_go     = (state_q == ST_RUN) && slot_ok;
  assign done_go    = (state_q == ST_DONE) && slot_ok;

  assign is_header = (in_data_i.data_byte & pcxrle_pkg::RunFlag) == pcxrle_pkg::RunFlag;
  assign zero_run  = (in_data_i.data_byte & pcxrle_pkg::RunMask) == '0;

  // one decoded byte per cycle while the pending slot can take it
  assign dec_fire = (active && !awaiting_q && !is_header) || run_go;
  assign dec_val  = (state_q == ST_RUN) ? run_value_q : in_data_i.data_byte;

  always_comb begin
    bpl_ext = CmpW'(bytes_line_q);
    if (bpl_ext == '0) begin
      bpl_eff = CmpW'(1);
    end else if (bpl_ext > CmpW'(MAX_LINE)) begin
      bpl_eff = CmpW'(MAX_LINE);
    end else begin
      bpl_eff = bpl_ext;
    end
  end

  assign pos_ext    = CmpW'(pos_q);
  assign pos_inc    = pos_ext + CmpW'(1);
  assign last_plane = !truecolor_q || (plane_q >= pcxrle_pkg::PlaneBlue);
  assign limit_ext  = truecolor_q ? CmpW'(width_q) : CmpW'(copy_q);
  assign span       = (limit_ext < bpl_eff) ? limit_ext : bpl_eff;
  assign row_end    = last_plane && (pos_inc == span);
  assign wrap       = pos_inc >= bpl_eff;
  assign row_inc    = row_q + RowW'(1);
  assign dec_stop   = dec_fire && wrap && last_plane && (row_inc >= height_q);

  assign wr_red   = dec_fire && truecolor_q && (plane_q == pcxrle_pkg::PlaneRed);
  assign wr_green = dec_fire && truecolor_q && (plane_q == pcxrle_pkg::PlaneGreen);
  assign rd_en    = dec_fire && truecolor_q && (plane_q >= pcxrle_pkg::PlaneBlue)
                    && (pos_ext < CmpW'(width_q));
  assign dec_emit = rd_en || (dec_fire && !truecolor_q && (pos_ext < CmpW'(copy_q)));

  // errors: zero-length run or data ending inside a row / before a run value
  assign err_hdr    = active && !awaiting_q && is_header && (zero_run || in_data_i.end_of_data);
  assign done_check = done_go && !stopped_q && eod_q;
  assign err_done   = done_check && ((pos_q != '0) || (plane_q != '0));

  assign push       = dec_emit || err_hdr || err_done;
  assign push_final = err_hdr || err_done;

  always_comb begin
    push_data             = '0;
    push_data.column      = pcxrle_pkg::ColW'(pos_q);
    push_data.row_index   = row_q;
    push_data.status      = pcxrle_pkg::STAT_DATA;
    if (dec_emit) begin
      push_data.first_byte = dec_val;
      push_data.row_end    = row_end;
    end else if (err_hdr && zero_run) begin
      push_data.status = pcxrle_pkg::STAT_ZERO_RUN;
    end else begin
      push_data.status = pcxrle_pkg::STAT_TRUNC;
    end
  end

  assign pend_move = pend_valid_q && out_free && (pend_final_q || push);

  // next state of the decoder
  always_comb begin
    state_d     = state_q;
    run_rem_d   = run_rem_q;
    run_value_d = run_value_q;
    awaiting_d  = awaiting_q;
    plane_d     = plane_q;
    pos_d       = pos_q;
    row_d       = row_q;
    stopped_d   = stopped_q;
    eod_d       = eod_q;

    if (accept) begin
      eod_d = in_data_i.end_of_data;
      if (!active) begin
        stopped_d = 1'b1;
      end
    end

    if (dec_fire) begin
      if (wrap) begin
        pos_d = '0;
        if (last_plane) begin
          plane_d = '0;
          row_d   = row_inc;
          if (dec_stop) begin
            stopped_d = 1'b1;
          end
        end else begin
          plane_d = plane_q + pcxrle_pkg::PlaneW'(1);
        end
      end else begin
        pos_d = PosW'(pos_inc);
      end
    end

    unique case (state_q)
      ST_IDLE: begin
        if (active) begin
          if (awaiting_q) begin
            awaiting_d  = 1'b0;
            run_value_d = in_data_i.data_byte;
            state_d     = ST_RUN;
          end else if (is_header) begin
            if (zero_run) begin
              stopped_d = 1'b1;
            end else begin
              run_rem_d  = pcxrle_pkg::RunW'(in_data_i.data_byte & pcxrle_pkg::RunMask);
              awaiting_d = 1'b1;
              if (in_data_i.end_of_data) begin
                stopped_d = 1'b1;
              end
            end
          end else begin
            run_value_d = in_data_i.data_byte;
            state_d     = ST_DONE;
          end
        end
      end
      ST_RUN: begin
        if (run_go) begin
          run_rem_d = run_rem_q - pcxrle_pkg::RunW'(1);
          if (run_rem_q == pcxrle_pkg::RunW'(1) || dec_stop) begin
            run_rem_d = '0;
            state_d   = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (done_go) begin
          state_d = ST_IDLE;
          if (done_check) begin
            stopped_d = 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      run_rem_q   <= '0;
      run_value_q <= '0;
      awaiting_q  <= 1'b0;
      plane_q     <= '0;
      pos_q       <= '0;
      row_q       <= '0;
      stopped_q   <= 1'b0;
      eod_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      run_rem_q   <= run_rem_d;
      run_value_q <= run_value_d;
      awaiting_q  <= awaiting_d;
      plane_q     <= plane_d;
      pos_q       <= pos_d;
      row_q       <= row_d;
      stopped_q   <= stopped_d;
      eod_q       <= eod_d;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      truecolor_q  <= 1'b0;
      bytes_line_q <= LenW'(1);
      width_q      <= LenW'(1);
      height_q     <= RowW'(1);
      copy_q       <= LenW'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        pcxrle_pkg::RegTruecolor: truecolor_q  <= cfg_data_i[0];
        pcxrle_pkg::RegBytesLine: bytes_line_q <= cfg_data_i[LenW-1:0];
        pcxrle_pkg::RegWidth:     width_q      <= cfg_data_i[LenW-1:0];
        pcxrle_pkg::RegHeight:    height_q     <= cfg_data_i[RowW-1:0];
        pcxrle_pkg::RegCopy:      copy_q       <= cfg_data_i[LenW-1:0];
        default: ;
      endcase
    end
  end

  // line buffers, registered read
  always_ff @(posedge clk_i) begin
    if (wr_red) begin
      red_mem[pos_q] <= dec_val;
    end
    if (rd_en) begin
      rd_red_q <= red_mem[pos_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_green) begin
      green_mem[pos_q] <= dec_val;
    end
    if (rd_en) begin
      rd_green_q <= green_mem[pos_q];
    end
  end

  // pending slot: holds a result until it is known whether it ends the request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      pend_final_q <= 1'b0;
    end else if (push) begin
      pend_valid_q <= 1'b1;
      pend_final_q <= push_final;
    end else if (pend_move) begin
      pend_valid_q <= 1'b0;
    end else if (done_go && pend_valid_q) begin
      pend_final_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      pend_q    <= push_data;
      pend_tc_q <= rd_en;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pend_move) begin
      out_valid_q <= 1'b1;
    end else if (out_free) begin
      out_valid_q <= 1'b0;
    end
  end

  always_comb begin
    out_d      = pend_q;
    out_d.last = pend_final_q;
    if (pend_tc_q) begin
      out_d.green_value = rd_green_q;
      out_d.red_value   = rd_red_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pend_move) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
